[rtl/core/smac_pkg.sv]
// Shared types, codes and constants of the shadow memory access checker.
package smac_pkg;

  // Shadow store geometry: one byte per 8-byte granule.
  localparam int unsigned SHADOW_ENTRIES = 65536;
  localparam int unsigned SHADOW_IDX_W   = $clog2(SHADOW_ENTRIES);

  // Fixed window sizes of the always-allowed areas.
  localparam logic [63:0] PHYS_WINDOW_SIZE   = 64'h0000_0800_0000_0000;
  localparam logic [63:0] SHADOW_WINDOW_SIZE = 64'h0000_1000_0000_0000;

  // Register reset values.
  localparam logic [63:0] REGION_BASE_RST    = 64'hFFFF_8000_0000_0000;
  localparam logic [63:0] LOW_HALF_LIMIT_RST = 64'h0000_7FFF_FFFF_FFFF;

  // Configuration port geometry: 64-bit registers at 8-byte strides.
  localparam int unsigned CFG_ADDR_W = 6;
  localparam logic [2:0] REG_ENABLE        = 3'd0;
  localparam logic [2:0] REG_REGION_BASE   = 3'd1;
  localparam logic [2:0] REG_LOW_HALF      = 3'd2;
  localparam logic [2:0] REG_PHYS_WINDOW   = 3'd3;
  localparam logic [2:0] REG_SHADOW_WINDOW = 3'd4;

  // Commands.
  localparam logic CMD_CHECK = 1'b0;
  localparam logic CMD_MARK  = 1'b1;

  // Mark kinds (the unused codes mark freed).
  localparam logic [1:0] MK_ACCESS  = 2'd0;
  localparam logic [1:0] MK_REDZONE = 2'd1;

  // Shadow byte codes.
  localparam logic [7:0] SH_REDZONE = 8'hFF;
  localparam logic [7:0] SH_FREED   = 8'hFE;

  // Result status codes.
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_UAF      = 3'd1;
  localparam logic [2:0] STAT_REDZONE  = 3'd2;
  localparam logic [2:0] STAT_INVALID  = 3'd3;
  localparam logic [2:0] STAT_RANGE    = 3'd4;

  // Request payload.
  typedef struct packed {
    logic        cmd;
    logic [63:0] addr;
    logic [20:0] length;
    logic        is_write;
    logic [1:0]  mark_kind;
  } smac_req_t;

  // Result payload.
  typedef struct packed {
    logic [2:0]        status;
    logic [63:0]       fault_addr;
    logic signed [7:0] fault_code;
    logic              fault_write;
  } smac_rsp_t;

  // Control sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_DECIDE,
    S_WALK,
    S_EVAL,
    S_DONE
  } smac_state_t;

endpackage

[rtl/core/smac_ram.sv]
// Generic single-port synchronous RAM with registered read data.
module smac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port share one address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/core/shadow_memory_access_checker_top.sv]
// Sequence from request to result: a check is prepared and decided, then each chunk is read and
// evaluated in turn until the walk ends, a chunk faults or a chunk is out of range; a skipped
// check goes straight to its result, and a mark writes its chunks (one write per cycle).
// Throughput: one request at a time; the next is taken once the sequencer is idle again.
// Reset: synchronous; afterwards a clearing pass writes all 65536 shadow bytes, one per cycle,
// during which no request is taken (configuration writes are taken as usual).
module shadow_memory_access_checker_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  smac_pkg::smac_req_t                req_data,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output smac_pkg::smac_rsp_t                rsp_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [smac_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [63:0]                        pwdata,
  output logic [63:0]                        prdata,
  output logic                               pready
);

  localparam int unsigned IW = smac_pkg::SHADOW_IDX_W;

  // Configuration registers.
  logic        enable;
  logic [63:0] region_base;
  logic [63:0] low_half_limit;
  logic [63:0] phys_window_base;
  logic [63:0] shadow_window_base;

  // Sequencer and working registers.
  smac_pkg::smac_state_t state, state_next;
  logic [IW-1:0]         clr_cnt;
  logic                  tripped;
  logic                  w_cmd;
  logic [63:0]           a;
  logic [20:0]           len;
  logic                  w_write;
  logic [1:0]            w_kind;
  logic                  one_zero;
  logic [64:0]           end_sum;
  logic [64:0]           phys_diff;
  logic [64:0]           shad_diff;
  logic                  bad;
  logic [63:0]           bad_addr;
  logic [63:0]           c_addr;
  logic [2:0]            c_off;
  logic [3:0]            c_len;
  smac_pkg::smac_rsp_t   res;

  // Memory port.
  logic          mem_we;
  logic [IW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  // Combinational walk and decision terms.
  logic          walk_active;
  logic [3:0]    room;
  logic [3:0]    chunk;
  logic [63:0]   idx_diff;
  logic          in_range;
  logic [7:0]    mark_byte;
  logic          skip;
  logic          low_ok;
  logic          phys_ok;
  logic          shad_ok;
  logic [4:0]    off_sum;
  logic [2:0]    eval_stat;
  logic          out_free;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable             <= 1'b0;
      region_base        <= smac_pkg::REGION_BASE_RST;
      low_half_limit     <= smac_pkg::LOW_HALF_LIMIT_RST;
      phys_window_base   <= '0;
      shadow_window_base <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        smac_pkg::REG_ENABLE:        enable             <= pwdata[0];
        smac_pkg::REG_REGION_BASE:   region_base        <= pwdata;
        smac_pkg::REG_LOW_HALF:      low_half_limit     <= pwdata;
        smac_pkg::REG_PHYS_WINDOW:   phys_window_base   <= pwdata;
        smac_pkg::REG_SHADOW_WINDOW: shadow_window_base <= pwdata;
        default: ;
      endcase
    end
  end

  // Configuration register reads.
  always_comb begin
    unique case (paddr[5:3])
      smac_pkg::REG_ENABLE:        prdata = {63'd0, enable};
      smac_pkg::REG_REGION_BASE:   prdata = region_base;
      smac_pkg::REG_LOW_HALF:      prdata = low_half_limit;
      smac_pkg::REG_PHYS_WINDOW:   prdata = phys_window_base;
      smac_pkg::REG_SHADOW_WINDOW: prdata = shadow_window_base;
      default:                     prdata = '0;
    endcase
  end

  // Chunk geometry and shadow index of the current walk address.
  always_comb begin
    walk_active = (len != 21'd0) || one_zero;
    room        = 4'd8 - {1'b0, a[2:0]};
    chunk       = (len < {17'd0, room}) ? len[3:0] : room;
    idx_diff    = a - region_base;
    in_range    = idx_diff[63:3] < 61'(smac_pkg::SHADOW_ENTRIES);
    if (w_kind == smac_pkg::MK_ACCESS) begin
      mark_byte = (chunk != 4'd8) ? {4'd0, chunk} : 8'd0;
    end else if (w_kind == smac_pkg::MK_REDZONE) begin
      mark_byte = smac_pkg::SH_REDZONE;
    end else begin
      mark_byte = smac_pkg::SH_FREED;
    end
  end

  // Skip decision: disabled, tripped, or wholly inside an allowed window.
  always_comb begin
    low_ok  = !end_sum[64] && (end_sum[63:0] <= low_half_limit) && (a < low_half_limit);
    phys_ok = !phys_diff[64] && (phys_diff[63:0] <= smac_pkg::PHYS_WINDOW_SIZE) &&
              ({43'd0, len} <= (smac_pkg::PHYS_WINDOW_SIZE - phys_diff[63:0]));
    shad_ok = !shad_diff[64] && (shad_diff[63:0] <= smac_pkg::SHADOW_WINDOW_SIZE) &&
              ({43'd0, len} <= (smac_pkg::SHADOW_WINDOW_SIZE - shad_diff[63:0]));
    skip    = !enable || tripped || low_ok || phys_ok || shad_ok;
  end

  // Chunk test against the shadow byte read back.
  always_comb begin
    off_sum = {2'd0, c_off} + {1'b0, c_len};
    if (mem_rdata == 8'd0) begin
      eval_stat = smac_pkg::STAT_OK;
    end else if (mem_rdata == smac_pkg::SH_FREED) begin
      eval_stat = smac_pkg::STAT_UAF;
    end else if (mem_rdata == smac_pkg::SH_REDZONE) begin
      eval_stat = smac_pkg::STAT_REDZONE;
    end else if (mem_rdata[7]) begin
      eval_stat = smac_pkg::STAT_INVALID;
    end else if (({5'd0, c_off} > mem_rdata) || ({3'd0, off_sum} > mem_rdata)) begin
      eval_stat = smac_pkg::STAT_INVALID;
    end else begin
      eval_stat = smac_pkg::STAT_OK;
    end
  end

  assign out_free = !rsp_valid || rsp_ready;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      smac_pkg::S_CLEAR: begin
        if (clr_cnt == IW'(smac_pkg::SHADOW_ENTRIES - 1)) state_next = smac_pkg::S_IDLE;
      end
      smac_pkg::S_IDLE: begin
        if (req_valid) state_next = smac_pkg::S_PREP;
      end
      smac_pkg::S_PREP: begin
        state_next = (w_cmd == smac_pkg::CMD_MARK) ? smac_pkg::S_WALK : smac_pkg::S_DECIDE;
      end
      smac_pkg::S_DECIDE: begin
        state_next = skip ? smac_pkg::S_DONE : smac_pkg::S_WALK;
      end
      smac_pkg::S_WALK: begin
        if (!walk_active) begin
          state_next = smac_pkg::S_DONE;
        end else if (w_cmd == smac_pkg::CMD_CHECK) begin
          state_next = in_range ? smac_pkg::S_EVAL : smac_pkg::S_DONE;
        end
      end
      smac_pkg::S_EVAL: begin
        state_next = (eval_stat != smac_pkg::STAT_OK) ? smac_pkg::S_DONE : smac_pkg::S_WALK;
      end
      smac_pkg::S_DONE: begin
        if (out_free) state_next = smac_pkg::S_IDLE;
      end
      default: state_next = smac_pkg::S_IDLE;
    endcase
  end

  // Output and memory control.
  always_comb begin
    req_ready = (state == smac_pkg::S_IDLE);
    mem_we    = 1'b0;
    mem_addr  = idx_diff[3 +: IW];
    mem_wdata = mark_byte;
    unique case (state)
      smac_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt;
        mem_wdata = 8'd0;
      end
      smac_pkg::S_WALK: begin
        mem_we = (w_cmd == smac_pkg::CMD_MARK) && walk_active && in_range;
      end
      default: ;
    endcase
  end

  // Sequencer state, clear counter and tripped flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= smac_pkg::S_CLEAR;
      clr_cnt <= '0;
      tripped <= 1'b0;
    end else begin
      state <= state_next;
      if (state == smac_pkg::S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if ((state == smac_pkg::S_WALK) && (w_cmd == smac_pkg::CMD_CHECK) &&
          walk_active && !in_range) begin
        tripped <= 1'b1;
      end
      if ((state == smac_pkg::S_EVAL) && (eval_stat != smac_pkg::STAT_OK)) tripped <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == smac_pkg::S_DONE) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == smac_pkg::S_DONE) && out_free) rsp_data <= res;
  end

  // Working registers of the walk.
  always_ff @(posedge clk) begin
    unique case (state)
      smac_pkg::S_IDLE: begin
        w_cmd   <= req_data.cmd;
        a       <= req_data.addr;
        len     <= req_data.length;
        w_write <= req_data.is_write;
        w_kind  <= req_data.mark_kind;
      end
      smac_pkg::S_PREP: begin
        end_sum   <= {1'b0, a} + {44'd0, len};
        phys_diff <= {1'b0, a} - {1'b0, phys_window_base};
        shad_diff <= {1'b0, a} - {1'b0, shadow_window_base};
        one_zero  <= (w_cmd == smac_pkg::CMD_CHECK) && (len == 21'd0) && (a[2:0] == 3'd0);
        bad       <= 1'b0;
        bad_addr  <= '0;
      end
      smac_pkg::S_DECIDE: begin
        res <= '0;
      end
      smac_pkg::S_WALK: begin
        if (!walk_active) begin
          // Walk finished: a mark reports its first out-of-range chunk, a check passes.
          res.status      <= bad ? smac_pkg::STAT_RANGE : smac_pkg::STAT_OK;
          res.fault_addr  <= bad_addr;
          res.fault_code  <= '0;
          res.fault_write <= 1'b0;
        end else begin
          c_addr   <= a;
          c_off    <= a[2:0];
          c_len    <= chunk;
          a        <= a + {60'd0, chunk};
          len      <= len - {17'd0, chunk};
          one_zero <= 1'b0;
          if ((w_cmd == smac_pkg::CMD_MARK) && !in_range && !bad) begin
            bad      <= 1'b1;
            bad_addr <= a;
          end
          if ((w_cmd == smac_pkg::CMD_CHECK) && !in_range) begin
            res.status      <= smac_pkg::STAT_RANGE;
            res.fault_addr  <= a;
            res.fault_code  <= '0;
            res.fault_write <= w_write;
          end
        end
      end
      smac_pkg::S_EVAL: begin
        if (eval_stat != smac_pkg::STAT_OK) begin
          res.status      <= eval_stat;
          res.fault_addr  <= c_addr;
          res.fault_code  <= mem_rdata;
          res.fault_write <= w_write;
        end
      end
      default: ;
    endcase
  end

  // Shadow byte store.
  smac_ram #(
    .WIDTH (8),
    .DEPTH (smac_pkg::SHADOW_ENTRIES)
  ) u_shadow (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // The tripped flag is sticky until reset.
  a_tripped_sticky: assert property (@(posedge clk) disable iff (rst)
    tripped |=> tripped)
    else $error("tripped flag cleared without reset");

  // A use-after-free result always carries the freed shadow code.
  a_uaf_code: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_data.status == smac_pkg::STAT_UAF)) |->
      (rsp_data.fault_code == smac_pkg::SH_FREED))
    else $error("use-after-free result with wrong shadow code");

  // An out-of-range result never carries a shadow code.
  a_range_code: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_data.status == smac_pkg::STAT_RANGE)) |->
      (rsp_data.fault_code == 8'sd0))
    else $error("out-of-range result with nonzero shadow code");

  // After a request is taken the sequencer is busy in the following cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while another is in progress");

endmodule
